/* rtl/core/gtr_pkg.sv */
// Shared types and constants for the glyph text renderer.
`default_nettype none

package gtr_pkg;

  // Fixed field widths
  localparam int FUNC_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 12;
  localparam int GADDR_W     = 12;
  localparam int GBYTE_W     = 8;
  localparam int PITCH_W     = 14;
  localparam int COLOR_W     = 32;
  localparam int INDEX_W     = 25;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Glyph store geometry
  localparam int STORE_DEPTH = 4096;
  localparam int GLYPH_WIDTH = 8;
  localparam int PAIRS_W     = 2;   // four pixel pairs per glyph row

  // Input word function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ORIGIN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG    = 2'd2;

  // Register reset values
  localparam logic [PITCH_W-1:0] PITCH_RESET = 14'd1024;
  localparam logic [COLOR_W-1:0] FG_RESET    = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] BG_RESET    = 32'h0000_0000;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  char_code;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [GADDR_W-1:0] glyph_addr;
    logic [GBYTE_W-1:0] glyph_byte;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] color_left;
    logic [COLOR_W-1:0] color_right;
    logic               last_of_char;
  } out_word_t;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch_words;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } cfg_t;

  // Glyph store access from the sequencer
  typedef struct packed {
    logic               we;
    logic [GADDR_W-1:0] waddr;
    logic [GBYTE_W-1:0] wdata;
    logic               re;
    logic [GADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/gtr_font_mem.sv */
// Glyph store: synchronous RAM, one write port and one registered read port.
`default_nettype none

module gtr_font_mem (
  input  wire logic                        clk,
  input  wire gtr_pkg::mem_req_t           req,
  output logic [gtr_pkg::GBYTE_W-1:0]      rdata
);
  import gtr_pkg::*;

  logic [GBYTE_W-1:0] mem [STORE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gtr_draw_seq.sv */
// Item decode, cursor state and glyph expansion into pixel-pair words.
`default_nettype none

module gtr_draw_seq #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256,
  parameter int COORD_BITS   = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire gtr_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire gtr_pkg::in_word_t            in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output gtr_pkg::out_word_t                out_word,
  output gtr_pkg::mem_req_t                 mem_req,
  input  wire logic [gtr_pkg::GBYTE_W-1:0]  mem_rdata
);
  import gtr_pkg::*;

  localparam int ROW_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int PROD_W = (COORD_BITS + PITCH_W > INDEX_W) ? COORD_BITS + PITCH_W : INDEX_W;
  localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(GLYPH_HEIGHT - 1);
  localparam logic [PAIRS_W-1:0] LAST_PAIR = '1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  // Glyph base address per character code, wrapped at the store depth
  typedef logic [GADDR_W-1:0] base_tab_t [256];

  function automatic base_tab_t build_base_tab();
    base_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = GADDR_W'((i % GLYPH_COUNT) * GLYPH_HEIGHT);
    end
    return t;
  endfunction

  localparam base_tab_t BASE_TAB = build_base_tab();

  logic [1:0]            state;
  logic [COORD_BITS-1:0] origin_col;
  logic [COORD_BITS-1:0] cursor_col;
  logic [COORD_BITS-1:0] cursor_row;
  logic [GADDR_W-1:0]    base;
  logic [INDEX_W-1:0]    line;
  logic [ROW_W-1:0]      row;
  logic [PAIRS_W-1:0]    pair;

  logic                  accept;
  logic                  load_out;
  logic                  last_row;
  logic [ROW_W-1:0]      row_inc;
  logic [PROD_W-1:0]     prod;
  logic [INDEX_W-1:0]    index_next;
  logic [2:0]            bit_left;
  logic [2:0]            bit_right;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign load_out = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign last_row = (row == LAST_ROW);
  assign row_inc  = row + 1'b1;

  // Start line of a character: cursor row times pitch
  assign prod = PROD_W'(cursor_row) * PROD_W'(cfg.pitch_words);

  // Pixel pair position and glyph bits, most significant bit leftmost
  assign index_next = line + INDEX_W'(cursor_col) + INDEX_W'({pair, 1'b0});
  assign bit_left   = {~pair, 1'b1};
  assign bit_right  = {~pair, 1'b0};

  // Glyph store requests: loads only in idle, reads only while drawing
  always_comb begin
    mem_req.we    = accept && (in_word.func == FUNC_LOAD);
    mem_req.waddr = in_word.glyph_addr;
    mem_req.wdata = in_word.glyph_byte;
    mem_req.re    = (state == ST_FETCH) ||
                    (load_out && (pair == LAST_PAIR) && !last_row);
    mem_req.raddr = base + GADDR_W'((state == ST_FETCH) ? row : row_inc);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_word.pixel_index  <= index_next;
      out_word.color_left   <= mem_rdata[bit_left]  ? cfg.fg_color : cfg.bg_color;
      out_word.color_right  <= mem_rdata[bit_right] ? cfg.fg_color : cfg.bg_color;
      out_word.last_of_char <= last_row && (pair == LAST_PAIR);
    end
  end

  // Sequencer and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      origin_col <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_word.func)
              FUNC_ORIGIN: begin
                origin_col <= COORD_BITS'(in_word.pos_x);
                cursor_col <= COORD_BITS'(in_word.pos_x);
                cursor_row <= COORD_BITS'(in_word.pos_y);
              end
              FUNC_DRAW: begin
                if (in_word.char_code == NEWLINE_CODE) begin
                  cursor_col <= origin_col;
                  cursor_row <= cursor_row + COORD_BITS'(GLYPH_HEIGHT);
                end else begin
                  base  <= BASE_TAB[in_word.char_code];
                  line  <= prod[INDEX_W-1:0];
                  row   <= '0;
                  state <= ST_FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          pair  <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out) begin
            pair <= pair + 1'b1;
            if (pair == LAST_PAIR) begin
              if (last_row) begin
                cursor_col <= cursor_col + COORD_BITS'(GLYPH_WIDTH);
                state      <= ST_IDLE;
              end else begin
                row  <= row_inc;
                line <= line + INDEX_W'(cfg.pitch_words);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A fetch is always followed by pair emission
  a_fetch_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |=> (state == ST_EMIT))
    else $error("fetch not followed by emit");

  // Store is never written while a glyph row is being read
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("glyph store read and write overlap");

  // The final pair of a character ends the draw
  a_last_ends_draw: assert property (@(posedge clk) disable iff (rst)
    (load_out && last_row && (pair == LAST_PAIR)) |=> (state == ST_IDLE))
    else $error("draw did not end after last pair");

  // Finishing a character advances the cursor by one glyph width
  a_cursor_advance: assert property (@(posedge clk) disable iff (rst)
    (load_out && last_row && (pair == LAST_PAIR)) |=>
      (cursor_col == $past(cursor_col) + COORD_BITS'(GLYPH_WIDTH)))
    else $error("cursor did not advance after character");

endmodule

`default_nettype wire

/* rtl/core/glyph_text_renderer.sv */
// Top level of the glyph text renderer: configuration registers, glyph store, sequencer.
//
//   Channel  Direction  Handshake          Word
//   cfg      in         cfg_we             cfg_index, cfg_data
//   in       in         in_valid/in_stall  gtr_pkg::in_word_t
//   out      out        out_valid/out_stall gtr_pkg::out_word_t
//
// Glyph loads, set-origin and newline words never stall the input.
// A drawn character is accepted, one glyph store read is made, then pixel pairs follow
// at one pixel pair per cycle while the output is not stalled.
// The next glyph row is read during the last pair of a row, so rows run back to back.
// Output stall holds the sequencer; input is stalled while a character is drawn.
// Reset (rst, synchronous) clears the cursor and registers; the glyph store is not cleared.
`default_nettype none

module glyph_text_renderer #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256,
  parameter int COORD_BITS   = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [gtr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire gtr_pkg::in_word_t               in_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output gtr_pkg::out_word_t                   out_word
);
  import gtr_pkg::*;

  cfg_t               cfg;
  mem_req_t           mem_req;
  logic [GBYTE_W-1:0] mem_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pitch_words <= PITCH_RESET;
      cfg.fg_color    <= FG_RESET;
      cfg.bg_color    <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PITCH: cfg.pitch_words <= cfg_data[PITCH_W-1:0];
        CFG_FG:    cfg.fg_color    <= cfg_data[COLOR_W-1:0];
        CFG_BG:    cfg.bg_color    <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gtr_font_mem u_font_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  gtr_draw_seq #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT),
    .COORD_BITS   (COORD_BITS)
  ) u_draw_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire

/* tb/gtr_tb_pkg.sv */
// Pixel-pair scoreboard and glyph expansion predictor for the glyph text renderer testbench.
package gtr_tb_pkg;
  import gtr_pkg::*;

  localparam int GLYPH_H = 16;

  class pixel_scoreboard;
    bit [GBYTE_W-1:0] font_rows [STORE_DEPTH];
    bit [POS_W-1:0]   origin_col;
    bit [POS_W-1:0]   cursor_col;
    bit [POS_W-1:0]   cursor_row;
    bit [PITCH_W-1:0] pitch;
    bit [COLOR_W-1:0] fg;
    bit [COLOR_W-1:0] bg;
    out_word_t        expected_pairs[$];
    int               mismatches;

    function new();
      pitch      = PITCH_RESET;
      fg         = FG_RESET;
      bg         = BG_RESET;
      mismatches = 0;
    endfunction

    // Register shadow; unused index changes nothing
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PITCH: pitch = data[PITCH_W-1:0];
        CFG_FG:    fg = data;
        CFG_BG:    bg = data;
        default: ;
      endcase
    endfunction

    // Update state for one accepted word and queue the pixel pairs it draws
    function void note_word(in_word_t w);
      out_word_t        pair;
      bit [GBYTE_W-1:0] rowbits;
      bit [31:0]        line;
      int               cy;
      int               cx;
      case (w.func)
        FUNC_LOAD: font_rows[w.glyph_addr] = w.glyph_byte;
        FUNC_ORIGIN: begin
          origin_col = w.pos_x;
          cursor_col = w.pos_x;
          cursor_row = w.pos_y;
        end
        FUNC_DRAW: begin
          if (w.char_code == NEWLINE_CODE) begin
            cursor_col = origin_col;
            cursor_row = cursor_row + POS_W'(GLYPH_H);
          end else begin
            for (cy = 0; cy < GLYPH_H; cy++) begin
              rowbits = font_rows[GADDR_W'(w.char_code * GLYPH_H + cy)];
              // pixel coordinates are not wrapped, only the final index
              line = (32'(cursor_row) + 32'(cy)) * 32'(pitch);
              for (cx = 0; cx < GLYPH_WIDTH; cx += 2) begin
                pair.pixel_index  = INDEX_W'(line + 32'(cursor_col) + 32'(cx));
                pair.color_left   = rowbits[7 - cx] ? fg : bg;
                pair.color_right  = rowbits[6 - cx] ? fg : bg;
                pair.last_of_char = (cy == GLYPH_H - 1) && (cx == GLYPH_WIDTH - 2);
                expected_pairs.push_back(pair);
              end
            end
            cursor_col = cursor_col + POS_W'(GLYPH_WIDTH);
          end
        end
        default: ;  // unused selector: no effect
      endcase
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one accepted pixel pair against the oldest expectation
    task check_pair(input out_word_t got);
      out_word_t want;
      if (expected_pairs.size() == 0) begin
        report($sformatf("pixel pair with nothing expected, index %0h", got.pixel_index));
        return;
      end
      want = expected_pairs.pop_front();
      if (got.pixel_index !== want.pixel_index)
        report($sformatf("pixel_index %0h, want %0h", got.pixel_index, want.pixel_index));
      if (got.color_left !== want.color_left)
        report($sformatf("color_left %0h, want %0h at index %0h",
                         got.color_left, want.color_left, want.pixel_index));
      if (got.color_right !== want.color_right)
        report($sformatf("color_right %0h, want %0h at index %0h",
                         got.color_right, want.color_right, want.pixel_index));
      if (got.last_of_char !== want.last_of_char)
        report($sformatf("last_of_char %0b, want %0b at index %0h",
                         got.last_of_char, want.last_of_char, want.pixel_index));
    endtask
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for the glyph text renderer: stimulus, receiver stall and checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gtr_pkg::*;
  import gtr_tb_pkg::*;

  localparam int IDLE_LIMIT      = 3000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int ITEMS_PER_PHASE = 46;
  localparam int HOLD_CYCLES     = 400;

  // Selector and register index with no function behind them
  localparam logic [FUNC_W-1:0]    FUNC_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;

  pixel_scoreboard sb;
  bit              ready_mark [256];
  int              ready_chars[$];
  int              burst_left = 0;
  bit              hold_req = 1'b0;
  int              idle_cycles = 0;

  glyph_text_renderer #(
    .GLYPH_HEIGHT(GLYPH_H),
    .GLYPH_COUNT (256),
    .COORD_BITS  (12)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #5ns clk = ~clk;

  function automatic in_word_t random_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_word_t)-1:0];
  endfunction

  // Offer one word, in bursts with random gaps; returns at the accepting edge
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // All sixteen rows of one glyph, biased toward empty and full rows
  task automatic load_glyph(input int code);
    in_word_t w;
    int       row;
    for (row = 0; row < GLYPH_H; row++) begin
      w = random_word();
      w.func = FUNC_LOAD;
      w.glyph_addr = GADDR_W'(code * GLYPH_H + row);
      case ($urandom_range(0, 3))
        0:       w.glyph_byte = '0;
        1:       w.glyph_byte = '1;
        default: ;
      endcase
      send_word(w);
    end
    if (!ready_mark[code]) begin
      ready_mark[code] = 1'b1;
      ready_chars.push_back(code);
    end
  endtask

  task automatic send_origin(input int x, input int y);
    in_word_t w;
    w = random_word();
    w.func  = FUNC_ORIGIN;
    w.pos_x = POS_W'(x);
    w.pos_y = POS_W'(y);
    send_word(w);
  endtask

  task automatic send_draw(input logic [CHAR_W-1:0] code);
    in_word_t w;
    w = random_word();
    w.func = FUNC_DRAW;
    w.char_code = code;
    send_word(w);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Stop offering, wait for every expected pair, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_pitch(input int p);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[PITCH_W-1:0] = PITCH_W'(p);
    set_reg(CFG_PITCH, data);
  endtask

  // Mostly draws of loaded glyphs, with font loads, origins, newlines and noise
  task automatic run_random(input int n);
    in_word_t w;
    int       done;
    int       pick;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (ready_chars.size() < 4 || pick < 10) begin
        load_glyph(ready_chars.size() < 2 ? 255 : $urandom_range(0, 255));
        done += GLYPH_H;
      end else if (pick < 18) begin
        w = random_word();
        w.func = FUNC_LOAD;
        send_word(w);
        done++;
      end else if (pick < 28) begin
        send_origin($urandom_range(0, 4095), $urandom_range(0, 4095));
        done++;
      end else if (pick < 36) begin
        send_draw(NEWLINE_CODE);
        done++;
      end else if (pick < 40) begin
        w = random_word();
        w.func = FUNC_SPARE;
        send_word(w);
      end else begin
        send_draw(CHAR_W'(ready_chars[$urandom_range(0, ready_chars.size() - 1)]));
        done++;
      end
    end
  endtask

  // Receiver stall: random segments, plus one long hold-off on request
  initial begin
    int seg_len;
    int mode;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        seg_len = $urandom_range(20, 120);
        mode = $urandom_range(0, 3);
        repeat (seg_len) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Monitors and watchdog; a pair with nothing expected is not progress
  always @(posedge clk) begin
    bit progress;
    if (!rst) begin
      progress = (in_valid && !in_stall) ||
                 (out_valid && !out_stall && (sb.expected_pairs.size() != 0));
      if (out_valid && !out_stall) sb.check_pair(out_word);
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (progress) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    in_word_t w;
    int       ph;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset colors, one glyph, origin extremes, wraps, unused selector
    load_glyph(0);
    w = random_word();
    w.func = FUNC_LOAD;
    w.glyph_addr = '1;
    w.glyph_byte = '1;
    send_word(w);
    send_origin(0, 0);
    send_draw(8'd0);
    send_draw(NEWLINE_CODE);
    send_draw(8'd0);
    w = random_word();
    w.func = FUNC_SPARE;
    send_word(w);
    send_origin(4095, 4095);
    send_draw(8'd0);
    send_draw(NEWLINE_CODE);  // row wraps past the top of the coordinate range
    send_draw(8'd0);

    // Random phases, each under a different register setting
    for (ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          set_pitch(1);
          set_reg(CFG_FG, '0);
          set_reg(CFG_BG, '1);
        end
        1: begin
          set_pitch(8192);
          set_reg(CFG_FG, $urandom());
          set_reg(CFG_BG, $urandom());
          hold_req = 1'b1;
        end
        2: begin
          set_pitch(0);
          set_reg(CFG_FG, $urandom());
          set_reg(CFG_BG, $urandom());
          set_reg(CFG_SPARE, $urandom());  // no register at this index
        end
        3: begin
          set_pitch(16383);
          set_reg(CFG_FG, '1);
          set_reg(CFG_BG, '0);
        end
        default: begin
          set_pitch($urandom_range(1, 64));
          set_reg(CFG_FG, $urandom());
          set_reg(CFG_BG, $urandom());
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end
    drain();

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
